// ----- rtl/rsp_pkg.sv -----
// Shared types, phase codes and helpers for the rate string parser.
// No dependencies; used by rsp_scale and rate_string_parser.
package rsp_pkg;

  localparam int unsigned RateW  = 64;
  localparam int unsigned PowerW = 3;
  localparam int unsigned AccExtW = RateW + 4;

  typedef enum logic [10:0] {
    PH_WS      = 11'b000_0000_0001,
    PH_SIGN    = 11'b000_0000_0010,
    PH_DIGITS  = 11'b000_0000_0100,
    PH_LETTERS = 11'b000_0000_1000,
    PH_BYTE1   = 11'b000_0001_0000,
    PH_BYTE2   = 11'b000_0010_0000,
    PH_BYTE3   = 11'b000_0100_0000,
    PH_BIT1    = 11'b000_1000_0000,
    PH_BIT2    = 11'b001_0000_0000,
    PH_BIT3    = 11'b010_0000_0000,
    PH_ERR     = 11'b100_0000_0000
  } phase_t;

  // scaler load request from the parser
  typedef struct packed {
    logic              restart;
    logic [PowerW-1:0] power;
    logic              binary;
    logic [RateW-1:0]  value;
  } scl_ctl_t;

  // scaler status back to the parser
  typedef struct packed {
    logic [PowerW-1:0] steps_left;
    logic [RateW-1:0]  value;
  } scl_sts_t;

  // x * 1024 or x * 1000 (= 1024 - 16 - 8), modulo 2^64
  function automatic logic [RateW-1:0] mul_base(input logic [RateW-1:0] x,
                                                input logic binary);
    logic [RateW-1:0] x1024;
    x1024 = x << 10;
    if (binary) begin
      return x1024;
    end
    return x1024 - (x << 4) - (x << 3);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

endpackage

// ----- rtl/rsp_scale.sv -----
// Unit scaler: multiplies the parsed value by 1000 or 1024 once per cycle
// until the requested power is used up. Depends on rsp_pkg.
module rsp_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  rsp_pkg::scl_ctl_t ctl,
  output rsp_pkg::scl_sts_t sts
);
  import rsp_pkg::*;

  logic [RateW-1:0]  scaled_r;
  logic [PowerW-1:0] cnt_r;
  logic              bin_r;
  logic [RateW-1:0]  stepped;

  assign stepped = mul_base(scaled_r, bin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.restart) begin
      cnt_r <= ctl.power;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - PowerW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.restart) begin
      scaled_r <= ctl.value;
      bin_r    <= ctl.binary;
    end else if (cnt_r != '0) begin
      scaled_r <= stepped;
    end
  end

  // last pending step is folded into the read
  assign sts.steps_left = cnt_r;
  assign sts.value      = (cnt_r != '0) ? stepped : scaled_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PowerW'(4)) else $error("scaler step count out of range");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.restart |=> cnt_r == $past(ctl.power)) else $error("scaler load lost");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!ctl.restart && cnt_r != '0) |=> cnt_r == $past(cnt_r) - PowerW'(1))
    else $error("scaler did not advance");

endmodule

// ----- rtl/rate_string_parser.sv -----
// Top level of the rate string parser: character decoder, digit accumulator
// and result register. Depends on rsp_pkg and rsp_scale.

// Takes one character per cycle on the in_ stream; every zero byte ends a
// string and yields one result on the out_ stream, status on out_tuser and the
// rate in bytes per second on out_tdata (0 when malformed). Characters are
// taken back to back; only a full result register that is not being drained
// holds off input. The unit multiplier works in the background, one factor
// of 1000 or 1024 per cycle, and the suffix is always long enough for it to
// finish before the terminator arrives.
module rate_string_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [0:0]  out_tuser,  // [0] status
  output logic [63:0] out_tdata   // [63:0] rate_bytes
);
  import rsp_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [RateW-1:0]   acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic               neg_r, neg_nxt;
  logic [PowerW-1:0]  pow_r, pow_nxt;
  logic               bin_r, bin_nxt;
  logic               byte_r, byte_nxt;

  logic               out_tvalid_r;
  logic               out_status_r;
  logic [RateW-1:0]   out_rate_r;

  logic [7:0]         ch;
  logic               in_acc;
  logic               term;
  logic [AccExtW-1:0] prod;
  logic [RateW-1:0]   signed_val;
  logic [RateW-1:0]   final_val;
  logic               ok;
  logic               unit_letter;
  scl_ctl_t           scl_ctl;
  scl_sts_t           scl_sts;

  assign ch        = in_tdata;
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign term      = (ch == 8'h00);

  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) +
                AccExtW'(ch - "0");
  assign signed_val = ovf_r ? '1 : (neg_r ? (RateW'(0) - acc_r) : acc_r);

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    neg_nxt     = neg_r;
    pow_nxt     = pow_r;
    bin_nxt     = bin_r;
    byte_nxt    = byte_r;
    unit_letter = 1'b0;

    if (is_digit(ch) && !ovf_r &&
        (phase_r == PH_WS || phase_r == PH_SIGN || phase_r == PH_DIGITS)) begin
      if (prod[AccExtW-1:RateW] != '0) begin
        ovf_nxt = 1'b1;
        acc_nxt = '1;
      end else begin
        acc_nxt = prod[RateW-1:0];
      end
    end

    case (phase_r)
      PH_WS: begin
        if (is_space(ch)) begin
          phase_nxt = PH_WS;
        end else if (ch == "+" || ch == "-") begin
          neg_nxt   = (ch == "-");
          phase_nxt = PH_SIGN;
        end else if (is_digit(ch)) begin
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_SIGN: begin
        phase_nxt = is_digit(ch) ? PH_DIGITS : PH_ERR;
      end
      PH_DIGITS, PH_LETTERS: begin
        if (phase_r == PH_DIGITS && is_digit(ch)) begin
          phase_nxt = PH_DIGITS;
        end else begin
          case (ch)
            "k", "K": begin
              pow_nxt = PowerW'(1); phase_nxt = PH_LETTERS; unit_letter = 1'b1;
            end
            "m", "M": begin
              pow_nxt = PowerW'(2); phase_nxt = PH_LETTERS; unit_letter = 1'b1;
            end
            "g", "G": begin
              pow_nxt = PowerW'(3); phase_nxt = PH_LETTERS; unit_letter = 1'b1;
            end
            "t", "T": begin
              pow_nxt = PowerW'(4); phase_nxt = PH_LETTERS; unit_letter = 1'b1;
            end
            "i", "I": begin
              if (pow_r == '0) begin
                phase_nxt = PH_ERR;
              end else begin
                bin_nxt     = 1'b1;
                phase_nxt   = PH_LETTERS;
                unit_letter = 1'b1;
              end
            end
            "B": phase_nxt = PH_BYTE1;
            "b": phase_nxt = PH_BIT1;
            default: phase_nxt = PH_ERR;
          endcase
        end
      end
      PH_BYTE1: phase_nxt = (ch == "p") ? PH_BYTE2 : PH_ERR;
      PH_BYTE2: begin
        if (ch == "s") begin
          byte_nxt  = 1'b1;
          phase_nxt = PH_BYTE3;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_BIT1: phase_nxt = (ch == "i") ? PH_BIT2 : PH_ERR;
      PH_BIT2: phase_nxt = (ch == "t") ? PH_BIT3 : PH_ERR;
      default: phase_nxt = PH_ERR;
    endcase
  end

  // reload the scaler whenever the digits end or the unit changes
  assign scl_ctl.restart = in_acc && !term &&
                           ((phase_r == PH_DIGITS && !is_digit(ch)) || unit_letter);
  assign scl_ctl.power   = pow_nxt;
  assign scl_ctl.binary  = bin_nxt;
  assign scl_ctl.value   = signed_val;

  rsp_scale u_scale (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (scl_ctl),
    .sts  (scl_sts)
  );

  assign ok        = (phase_r == PH_DIGITS) || (phase_r == PH_BYTE3) ||
                     (phase_r == PH_BIT3);
  assign final_val = (phase_r == PH_DIGITS) ? signed_val : scl_sts.value;

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && term)) begin
      phase_r <= PH_WS;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      neg_r   <= 1'b0;
      pow_r   <= '0;
      bin_r   <= 1'b0;
      byte_r  <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      neg_r   <= neg_nxt;
      pow_r   <= pow_nxt;
      bin_r   <= bin_nxt;
      byte_r  <= byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_acc && term) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && term) begin
      out_status_r <= !ok;
      out_rate_r   <= !ok ? '0 : (byte_r ? final_val : (final_val >> 3));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_rate_r;

  a_scale_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && term && (phase_r == PH_BYTE3 || phase_r == PH_BIT3))
      |-> scl_sts.steps_left <= PowerW'(1))
    else $error("unit scaling unfinished at terminator");

  a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && term) |=> (phase_r == PH_WS && pow_r == '0 && !ovf_r))
    else $error("parser state not cleared after terminator");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tdata == '0)
    else $error("malformed string with nonzero rate");

endmodule
